[hw/rtl/bdp_pkg.sv]
// Shared types, constants and helpers for the delta patch decoder.
package bdp_pkg;

    localparam int HEADER_BYTES = 6;
    localparam int END_W        = 24;
    localparam int WFIELD_W     = 4;
    localparam int POS_W        = 32;
    localparam int BYTE_W       = 8;
    localparam int CNT_W        = 8;
    localparam int CFG_ADDR_W   = 2;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 112;
    localparam int OUT_TUSER_W  = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_PATCH_END  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SKIP_WIDTH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COPY_WIDTH = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ADD_WIDTH  = 2'd3;

    typedef enum logic [1:0] {
        KIND_COPY    = 2'd0,
        KIND_LITERAL = 2'd1,
        KIND_FINISH  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_SKIPW = 3'd0,
        PH_SKIPV = 3'd1,
        PH_COPYW = 3'd2,
        PH_COPYV = 3'd3,
        PH_ADDW  = 3'd4,
        PH_ADDV  = 3'd5,
        PH_LIT   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BIT   = 2'd1,
        ST_TAIL  = 2'd2,
        ST_FLUSH = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       take;
        logic [2:0] bit_sel;
        logic       flush;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } stat_t;

    typedef struct packed {
        kind_t             kind;
        logic [POS_W-1:0]  old_offset;
        logic [POS_W-1:0]  dest_offset;
        logic [POS_W-1:0]  length;
        logic [BYTE_W-1:0] literal;
        logic              error;
    } result_t;

    // A width field register of zero counts as one bit, anything above eight as eight.
    function automatic logic [CNT_W-1:0] clamp_width(input logic [WFIELD_W-1:0] w);
        logic [CNT_W-1:0] r;
        if (w == '0) begin
            r = 8'd1;
        end else if (w > 4'd8) begin
            r = 8'd8;
        end else begin
            r = {4'd0, w};
        end
        return r;
    endfunction

endpackage

[hw/rtl/bdp_ctrl.sv]
// Sequencer that walks each patch byte bit by bit and hands results out.
module bdp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  bdp_pkg::stat_t stat,
    output bdp_pkg::cmd_t  cmd
);

    bdp_pkg::ctrl_state_t state_reg, state_next;
    logic [2:0]           cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bdp_pkg::ST_IDLE;
            cnt_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            bdp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = 3'd7;
                    state_next = bdp_pkg::ST_BIT;
                end
            end
            bdp_pkg::ST_BIT: begin
                if (!stat.out_busy) begin
                    cmd.step    = 1'b1;
                    cmd.take    = 1'b1;
                    cmd.bit_sel = cnt_reg;
                    if (cnt_reg == 3'd0) begin
                        state_next = bdp_pkg::ST_TAIL;
                    end else begin
                        cnt_next = cnt_reg - 3'd1;
                    end
                end
            end
            bdp_pkg::ST_TAIL: begin
                // End check after the final bit of the byte.
                if (!stat.out_busy) begin
                    cmd.step   = 1'b1;
                    state_next = bdp_pkg::ST_FLUSH;
                end
            end
            bdp_pkg::ST_FLUSH: begin
                if (!stat.out_busy) begin
                    cmd.flush  = 1'b1;
                    state_next = bdp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bdp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/bdp_datapath.sv]
// Bit parser, position counters, result holding stage and output register.
module bdp_datapath #(
    parameter int MAX_VALUE_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [bdp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [bdp_pkg::END_W-1:0]           cfg_wdata,
    input  logic [bdp_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  bdp_pkg::cmd_t                       cmd,
    output bdp_pkg::stat_t                      stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bdp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [bdp_pkg::OUT_TUSER_W-1:0]     m_tuser,
    output logic                                m_tlast
);

    localparam int MV = MAX_VALUE_BITS;

    logic [bdp_pkg::END_W-1:0]    end_reg;
    logic [bdp_pkg::WFIELD_W-1:0] skipw_reg, copyw_reg, addw_reg;

    logic [bdp_pkg::BYTE_W-1:0] byte_reg, byte_next;
    bdp_pkg::phase_t            phase_reg, phase_next;
    logic [MV-1:0]              acc_reg, acc_next;
    logic [bdp_pkg::CNT_W-1:0]  gath_reg, gath_next;
    logic [bdp_pkg::CNT_W-1:0]  curw_reg, curw_next;
    logic [MV-1:0]              rem_reg, rem_next;
    logic [bdp_pkg::POS_W-1:0]  oldp_reg, oldp_next;
    logic [bdp_pkg::POS_W-1:0]  newp_reg, newp_next;
    logic [bdp_pkg::POS_W-1:0]  bits_reg, bits_next;
    logic                       fin_reg, fin_next;
    logic                       err_reg, err_next;

    logic                       hold_valid_reg, hold_valid_next;
    bdp_pkg::result_t           hold_reg, hold_next;
    logic                       out_valid_reg, out_valid_next;
    bdp_pkg::result_t           out_reg, out_next;
    logic                       out_last_reg, out_last_next;

    logic                       bit_in;
    logic [MV-1:0]              acc_new;
    logic [bdp_pkg::CNT_W-1:0]  gath_new;
    logic [bdp_pkg::CNT_W-1:0]  target;
    logic [MV-1:0]              rem_dec;
    logic                       finish_cond;
    logic                       produce;
    bdp_pkg::result_t           res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_reg   <= '0;
            skipw_reg <= 4'd1;
            copyw_reg <= 4'd1;
            addw_reg  <= 4'd1;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                bdp_pkg::CFG_PATCH_END:  end_reg   <= cfg_wdata;
                bdp_pkg::CFG_SKIP_WIDTH: skipw_reg <= cfg_wdata[bdp_pkg::WFIELD_W-1:0];
                bdp_pkg::CFG_COPY_WIDTH: copyw_reg <= cfg_wdata[bdp_pkg::WFIELD_W-1:0];
                bdp_pkg::CFG_ADD_WIDTH:  addw_reg  <= cfg_wdata[bdp_pkg::WFIELD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= bdp_pkg::PH_SKIPW;
            acc_reg        <= '0;
            gath_reg       <= '0;
            curw_reg       <= '0;
            rem_reg        <= '0;
            oldp_reg       <= '0;
            newp_reg       <= '0;
            bits_reg       <= 32'(bdp_pkg::HEADER_BYTES * 8);
            fin_reg        <= 1'b0;
            err_reg        <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            gath_reg       <= gath_next;
            curw_reg       <= curw_next;
            rem_reg        <= rem_next;
            oldp_reg       <= oldp_next;
            newp_reg       <= newp_next;
            bits_reg       <= bits_next;
            fin_reg        <= fin_next;
            err_reg        <= err_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign bit_in   = byte_reg[cmd.bit_sel];
    assign acc_new  = {acc_reg[MV-2:0], bit_in};
    assign gath_new = gath_reg + 8'd1;
    assign rem_dec  = rem_reg - MV'(1);

    always_comb begin
        case (phase_reg)
            bdp_pkg::PH_SKIPW: target = bdp_pkg::clamp_width(skipw_reg);
            bdp_pkg::PH_COPYW: target = bdp_pkg::clamp_width(copyw_reg);
            bdp_pkg::PH_ADDW:  target = bdp_pkg::clamp_width(addw_reg);
            bdp_pkg::PH_LIT:   target = 8'd8;
            default:           target = curw_reg;
        endcase
    end

    // The end position is only tested where a COPY or ADD command would begin.
    assign finish_cond = !fin_reg && (gath_reg == '0)
        && (phase_reg == bdp_pkg::PH_SKIPW || phase_reg == bdp_pkg::PH_ADDW)
        && (bits_reg >= {8'd0, end_reg});

    always_comb begin
        byte_next  = byte_reg;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        gath_next  = gath_reg;
        curw_next  = curw_reg;
        rem_next   = rem_reg;
        oldp_next  = oldp_reg;
        newp_next  = newp_reg;
        bits_next  = bits_reg;
        fin_next   = fin_reg;
        err_next   = err_reg;
        produce    = 1'b0;
        res        = '0;

        if (cmd.load) begin
            byte_next = s_tdata;
        end

        if (cmd.step) begin
            if (finish_cond) begin
                fin_next        = 1'b1;
                produce         = 1'b1;
                res.kind        = bdp_pkg::KIND_FINISH;
                res.dest_offset = newp_reg;
                res.error       = err_reg;
            end else if (cmd.take && !fin_reg) begin
                bits_next = bits_reg + 32'd1;
                if (gath_new < target) begin
                    acc_next  = acc_new;
                    gath_next = gath_new;
                end else begin
                    acc_next  = '0;
                    gath_next = '0;
                    case (phase_reg)
                        bdp_pkg::PH_SKIPW, bdp_pkg::PH_COPYW, bdp_pkg::PH_ADDW: begin
                            if (acc_new == '0) begin
                                if (phase_reg == bdp_pkg::PH_SKIPW) begin
                                    phase_next = bdp_pkg::PH_COPYW;
                                end else if (phase_reg == bdp_pkg::PH_ADDW) begin
                                    phase_next = bdp_pkg::PH_SKIPW;
                                end else begin
                                    // Zero count width gives an empty copy.
                                    produce         = 1'b1;
                                    res.kind        = bdp_pkg::KIND_COPY;
                                    res.old_offset  = oldp_reg;
                                    res.dest_offset = newp_reg;
                                    phase_next      = bdp_pkg::PH_ADDW;
                                end
                            end else begin
                                if (acc_new > MV'(MAX_VALUE_BITS)) begin
                                    err_next = 1'b1;
                                end
                                curw_next = acc_new[bdp_pkg::CNT_W-1:0];
                                if (phase_reg == bdp_pkg::PH_SKIPW) begin
                                    phase_next = bdp_pkg::PH_SKIPV;
                                end else if (phase_reg == bdp_pkg::PH_COPYW) begin
                                    phase_next = bdp_pkg::PH_COPYV;
                                end else begin
                                    phase_next = bdp_pkg::PH_ADDV;
                                end
                            end
                        end
                        bdp_pkg::PH_SKIPV: begin
                            oldp_next  = oldp_reg + 32'(acc_new);
                            phase_next = bdp_pkg::PH_COPYW;
                        end
                        bdp_pkg::PH_COPYV: begin
                            produce         = 1'b1;
                            res.kind        = bdp_pkg::KIND_COPY;
                            res.old_offset  = oldp_reg;
                            res.dest_offset = newp_reg;
                            res.length      = 32'(acc_new);
                            oldp_next       = oldp_reg + 32'(acc_new);
                            newp_next       = newp_reg + 32'(acc_new);
                            phase_next      = bdp_pkg::PH_ADDW;
                        end
                        bdp_pkg::PH_ADDV: begin
                            rem_next   = acc_new;
                            phase_next = (acc_new == '0) ? bdp_pkg::PH_SKIPW
                                                         : bdp_pkg::PH_LIT;
                        end
                        default: begin
                            produce         = 1'b1;
                            res.kind        = bdp_pkg::KIND_LITERAL;
                            res.dest_offset = newp_reg;
                            res.literal     = acc_new[bdp_pkg::BYTE_W-1:0];
                            newp_next       = newp_reg + 32'd1;
                            rem_next        = rem_dec;
                            if (rem_dec == '0) begin
                                phase_next = bdp_pkg::PH_SKIPW;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Each result waits in the hold stage until the next one shows up or the
    // byte ends, so that its last flag is known when it moves to the output.
    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg & ~m_tready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        if (produce) begin
            if (hold_valid_reg) begin
                out_valid_next = 1'b1;
                out_next       = hold_reg;
                out_last_next  = 1'b0;
            end
            hold_next       = res;
            hold_valid_next = 1'b1;
        end else if (cmd.flush && hold_valid_reg) begin
            out_valid_next  = 1'b1;
            out_next        = hold_reg;
            out_last_next   = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    assign stat.out_busy = out_valid_reg & ~m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {7'd0, out_reg.error, out_reg.literal, out_reg.length,
                       out_reg.dest_offset, out_reg.old_offset};

endmodule

[hw/rtl/binary_delta_patch_decoder.sv]
// Top level of the delta patch decoder: sequencer plus datapath.
//
//   Port group   Direction  Moves
//   s_*          in         one patch body byte per request
//   m_*          out        copy directive, literal byte or finish per request
//   cfg_*        in         register write: end position and field widths
//
// A byte is accepted, then its bits go one bit per cycle through the shared
// field accumulator while the output is not stalled, then the end check runs
// and the held result is released with its last flag. A result stalled at
// the output holds the sequencer until it is taken. Reset is synchronous on
// aresetn and returns the parser to the start of a COPY command with the header
// bits counted. A new byte is accepted while an earlier result still waits at the output.
module binary_delta_patch_decoder #(
    parameter int MAX_VALUE_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [bdp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [bdp_pkg::END_W-1:0]           cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bdp_pkg::IN_TDATA_W-1:0]      s_tdata,   // [7:0] patch_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] old_offset, [63:32] dest_offset, [95:64] length,
    // [103:96] literal, [104] error, [111:105] zero
    output logic [bdp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [bdp_pkg::OUT_TUSER_W-1:0]     m_tuser,   // [1:0] kind
    output logic                                m_tlast
);

    bdp_pkg::cmd_t  cmd;
    bdp_pkg::stat_t stat;

    bdp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bdp_datapath #(
        .MAX_VALUE_BITS (MAX_VALUE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Once a byte is taken, the block works on it before taking another.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again right after a request");

    // Nothing follows a finish within the same byte.
    a_finish_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == bdp_pkg::KIND_FINISH) |-> m_tlast)
        else $error("finish result without last flag");

    // The error flag is only reported on a finish.
    a_error_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != bdp_pkg::KIND_FINISH) |-> !m_tdata[104])
        else $error("error flag on a copy or literal result");

endmodule

[bench/binary_delta_patch_decoder_tb.sv]
// Self-checking bench for the delta patch decoder: patch byte stream in, copy/literal/finish out.
module binary_delta_patch_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bdp_pkg::*;

    localparam int VALUE_BITS = 32;

    typedef struct {
        phase_t      phase;
        logic [31:0] acc;
        int unsigned gathered;
        int unsigned vwidth;
        logic [31:0] lits_left;
        logic [31:0] old_pos;
        logic [31:0] new_pos;
        logic [31:0] bits_used;
        logic        done;
        logic        werr;
    } parse_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] old_off;
        logic [31:0] dest_off;
        logic [31:0] len;
        logic [7:0]  lit;
        logic        err;
        logic        last;
    } patch_result_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        typed;
        kind_t       kind;
        logic [31:0] old_off;
        logic [31:0] dest_off;
        logic [31:0] len;
        logic [7:0]  lit;
    } stim_row_t;

    // Opening stream, run with all field widths at eight so every width field is one byte.
    localparam stim_row_t OPENING [22] = '{
        '{8'h00, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'h08, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'hff, 1'b1, KIND_COPY,    32'd0,   32'd0,   32'd255, 8'h00},
        '{8'h08, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'h02, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'h00, 1'b1, KIND_LITERAL, 32'd0,   32'd255, 32'd0,   8'h00},
        '{8'hff, 1'b1, KIND_LITERAL, 32'd0,   32'd256, 32'd0,   8'hff},
        '{8'h20, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'hff, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'hff, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'hff, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'hff, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'h00, 1'b1, KIND_COPY,    32'd254, 32'd257, 32'd0,   8'h00},
        '{8'h00, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'h28, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'hab, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'h00, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'h00, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'h00, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'h01, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'h08, 1'b0, KIND_COPY,    32'd0,   32'd0,   32'd0,   8'h00},
        '{8'h80, 1'b1, KIND_COPY,    32'd255, 32'd257, 32'd128, 8'h00}
    };

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wen;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [END_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;

    logic [END_W-1:0]       end_mark;
    logic [3:0]             skip_fw;
    logic [3:0]             copy_fw;
    logic [3:0]             add_fw;
    parse_state_t           parse;
    patch_result_t          pending_results [$];
    logic [31:0]            field_plan;
    int                     mismatches = 0;
    bit                     send_calm = 1'b0;
    bit                     recv_calm = 1'b0;

    binary_delta_patch_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int unsigned clamped_width(input logic [3:0] w);
        if (w == 4'd0) return 1;
        if (w > 4'd8) return 8;
        return w;
    endfunction

    function automatic int unsigned field_width(input parse_state_t st);
        case (st.phase)
            PH_SKIPW: return clamped_width(skip_fw);
            PH_COPYW: return clamped_width(copy_fw);
            PH_ADDW:  return clamped_width(add_fw);
            PH_LIT:   return 8;
            default:  return st.vwidth;
        endcase
    endfunction

    function automatic void open_value(inout parse_state_t st, input logic [31:0] w,
                                       input phase_t nxt);
        if (w > VALUE_BITS) st.werr = 1'b1;
        st.vwidth = w;
        st.phase  = nxt;
    endfunction

    // One patch bit; at most one copy directive or literal can complete on it.
    function automatic void shift_in_bit(inout parse_state_t st, input logic b,
                                         output logic got, output patch_result_t r);
        logic [31:0] v;
        logic        do_copy;
        got     = 1'b0;
        r       = '0;
        do_copy = 1'b0;
        st.acc       = {st.acc[30:0], b};
        st.gathered  = st.gathered + 1;
        st.bits_used = st.bits_used + 1;
        if (st.gathered < field_width(st)) return;
        v           = st.acc;
        st.acc      = '0;
        st.gathered = 0;
        case (st.phase)
            PH_SKIPW: begin
                if (v == 0) st.phase = PH_COPYW;
                else open_value(st, v, PH_SKIPV);
            end
            PH_SKIPV: begin
                st.old_pos = st.old_pos + v;
                st.phase   = PH_COPYW;
            end
            PH_COPYW: begin
                if (v == 0) do_copy = 1'b1;
                else open_value(st, v, PH_COPYV);
            end
            PH_COPYV: do_copy = 1'b1;
            PH_ADDW: begin
                if (v == 0) st.phase = PH_SKIPW;
                else open_value(st, v, PH_ADDV);
            end
            PH_ADDV: begin
                st.lits_left = v;
                st.phase     = (v == 0) ? PH_SKIPW : PH_LIT;
            end
            default: begin
                got          = 1'b1;
                r.kind       = KIND_LITERAL;
                r.dest_off   = st.new_pos;
                r.lit        = v[7:0];
                st.new_pos   = st.new_pos + 1;
                st.lits_left = st.lits_left - 1;
                if (st.lits_left == 0) st.phase = PH_SKIPW;
            end
        endcase
        // A zero count width yields a copy of length zero, so v is the length either way.
        if (do_copy) begin
            got        = 1'b1;
            r.kind     = KIND_COPY;
            r.old_off  = st.old_pos;
            r.dest_off = st.new_pos;
            r.len      = v;
            st.old_pos = st.old_pos + v;
            st.new_pos = st.new_pos + v;
            st.phase   = PH_ADDW;
        end
    endfunction

    // The end position is only tested where a COPY or ADD command would begin.
    function automatic void end_check(inout parse_state_t st, output logic got,
                                      output patch_result_t r);
        got = 1'b0;
        r   = '0;
        if (st.done || st.gathered != 0) return;
        if (st.phase != PH_SKIPW && st.phase != PH_ADDW) return;
        if (st.bits_used < {8'd0, end_mark}) return;
        st.done    = 1'b1;
        got        = 1'b1;
        r.kind     = KIND_FINISH;
        r.dest_off = st.new_pos;
        r.err      = st.werr;
    endfunction

    function automatic int decode_patch_byte(inout parse_state_t st, input logic [7:0] b,
                                             output patch_result_t res [9]);
        int            n;
        logic          got;
        patch_result_t r;
        n = 0;
        for (int i = 7; i >= 0; i--) begin
            end_check(st, got, r);
            if (got) begin
                res[n] = r;
                n++;
            end
            if (st.done) break;
            shift_in_bit(st, b[i], got, r);
            if (got) begin
                res[n] = r;
                n++;
            end
        end
        end_check(st, got, r);
        if (got) begin
            res[n] = r;
            n++;
        end
        if (n > 0) res[n-1].last = 1'b1;
        return n;
    endfunction

    // Picks the value of the field about to start; counts stay small so that
    // the stream keeps moving through whole commands.
    function automatic void plan_field(input parse_state_t st);
        int unsigned fw;
        int unsigned top;
        int unsigned pick;
        fw   = field_width(st);
        pick = $urandom_range(0, 99);
        case (st.phase)
            PH_SKIPW, PH_COPYW, PH_ADDW: begin
                top = (1 << fw) - 1;
                if (pick < 20) field_plan = '0;
                else if (pick < 88) field_plan = $urandom_range(1, (top < 6) ? top : 6);
                else if (pick < 93) field_plan = (top < 32) ? top : 32;
                else field_plan = $urandom_range(1, top);
            end
            PH_SKIPV, PH_COPYV: begin
                if (pick < 10) field_plan = '1;
                else if (pick < 20) field_plan = '0;
                else field_plan = $urandom;
            end
            PH_ADDV: field_plan = $urandom_range(0, (fw >= 3) ? 6 : (1 << fw) - 1);
            default: field_plan = $urandom_range(0, 255);
        endcase
    endfunction

    // Builds the next byte by walking a private copy of the parser state. Noisy
    // bytes take random bits everywhere except in the literal count.
    function automatic logic [7:0] compose_byte(input parse_state_t st, input bit noisy);
        logic [7:0]    b;
        int            j;
        logic          got;
        patch_result_t r;
        for (int i = 7; i >= 0; i--) begin
            if (st.gathered == 0) plan_field(st);
            j = int'(field_width(st)) - 1 - int'(st.gathered);
            if (noisy && st.phase != PH_ADDV) b[i] = 1'($urandom_range(0, 1));
            else b[i] = (j < 32) ? field_plan[j] : 1'b0;
            shift_in_bit(st, b[i], got, r);
        end
        return b;
    endfunction

    function automatic string describe(input patch_result_t r);
        return $sformatf("kind %0d old %h dest %h len %h lit %h err %b last %b",
                         r.kind, r.old_off, r.dest_off, r.len, r.lit, r.err, r.last);
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [END_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            CFG_PATCH_END:  end_mark = val;
            CFG_SKIP_WIDTH: skip_fw  = val[3:0];
            CFG_COPY_WIDTH: copy_fw  = val[3:0];
            CFG_ADD_WIDTH:  add_fw   = val[3:0];
        endcase
        @(negedge aclk);
    endtask

    task automatic set_all(input logic [END_W-1:0] end_bits, input logic [3:0] sw,
                           input logic [3:0] cw, input logic [3:0] aw);
        write_reg(CFG_PATCH_END, end_bits);
        write_reg(CFG_SKIP_WIDTH, {20'd0, sw});
        write_reg(CFG_COPY_WIDTH, {20'd0, cw});
        write_reg(CFG_ADD_WIDTH, {20'd0, aw});
    endtask

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_byte(input logic [7:0] b, input logic typed, input patch_result_t given);
        int            gap;
        int            n;
        patch_result_t res [9];
        if ($urandom_range(0, 11) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        n = decode_patch_byte(parse, b, res);
        if (typed) pending_results.push_back(given);
        else for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Lets every expected result arrive, then covers a byte that is still being parsed.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        int unsigned   gap;
        patch_result_t want;
        patch_result_t got;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 11) == 0) recv_calm = !recv_calm;
            gap = recv_calm ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.kind     = kind_t'(m_tuser);
            got.old_off  = m_tdata[31:0];
            got.dest_off = m_tdata[63:32];
            got.len      = m_tdata[95:64];
            got.lit      = m_tdata[103:96];
            got.err      = m_tdata[104];
            got.last     = m_tlast;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: %s", $time, describe(got));
            end else begin
                want = pending_results.pop_front();
                if (want !== got) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result mismatch, expected %s", $time, describe(want));
                        $display("    actual %s", describe(got));
                    end
                end
            end
            @(negedge aclk);
        end
    end

    initial begin
        patch_result_t given;
        int            tail;
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_addr  = CFG_PATCH_END;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;

        end_mark        = '0;
        skip_fw         = 4'd1;
        copy_fw         = 4'd1;
        add_fw          = 4'd1;
        parse.phase     = PH_SKIPW;
        parse.acc       = '0;
        parse.gathered  = 0;
        parse.vwidth    = 0;
        parse.lits_left = '0;
        parse.old_pos   = '0;
        parse.new_pos   = '0;
        parse.bits_used = HEADER_BYTES * 8;
        parse.done      = 1'b0;
        parse.werr      = 1'b0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_all(24'hffffff, 4'd8, 4'd8, 4'd8);
        foreach (OPENING[k]) begin
            given          = '0;
            given.kind     = OPENING[k].kind;
            given.old_off  = OPENING[k].old_off;
            given.dest_off = OPENING[k].dest_off;
            given.len      = OPENING[k].len;
            given.lit      = OPENING[k].lit;
            given.last     = 1'b1;
            send_byte(OPENING[k].data, OPENING[k].typed, given);
        end

        for (int p = 0; p < 5; p++) begin
            settle();
            case (p)
                0: set_all(24'hffffff, 4'd1, 4'd1, 4'd1);
                1: set_all(24'($urandom_range(24'hffffff, 100000)), 4'd0, 4'd0, 4'd0);
                2: set_all(24'hffffff, 4'd15, 4'd15, 4'd15);
                default: set_all(24'($urandom_range(24'hffffff, 100000)),
                                 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                 4'($urandom_range(0, 15)));
            endcase
            repeat (17) send_byte(compose_byte(parse, $urandom_range(0, 6) == 0), 1'b0, '0);
        end

        // An end position of zero is already passed, so the next command start finishes;
        // a few bytes after that must be swallowed without results.
        settle();
        write_reg(CFG_PATCH_END, '0);
        tail = 0;
        for (int k = 0; k < 64 && tail < 3; k++) begin
            send_byte(compose_byte(parse, 1'b0), 1'b0, '0);
            if (parse.done) tail++;
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
